// ===== design/assert_macros.svh =====
// Assertion macros used by the checker module of the frame sync checker.
// Each macro expands to one labeled concurrent assertion with a disable iff reset guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MCFSC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define MCFSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== design/mcfsc_pkg.sv =====
// Shared types, constants and helper functions for the frame sync checker.
// Depends on nothing; the cfg, ctrl, datapath and top-level modules import it.
package mcfsc_pkg;

  localparam int CAMERAS = 4;
  localparam int SLOTS   = 8;

  localparam int CAM_W  = (CAMERAS > 1) ? $clog2(CAMERAS) : 1;
  localparam int CI_W   = $clog2(CAMERAS + 1);
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SJ_W   = $clog2(SLOTS + 1);
  localparam int HIT_W  = $clog2(CAMERAS + 1);

  localparam int KIND_W     = 1;
  localparam int CAM_ID_W   = 2;
  localparam int FSEQ_W     = 31;
  localparam int SEC_W      = 32;
  localparam int USEC_W     = 20;
  localparam int COUNT_W    = 3;
  localparam int TOL_W      = 8;
  localparam int TIME_W     = 42;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Milliseconds from seconds and microseconds. The microsecond divide by 1000 is a
  // reciprocal multiply that is exact for every 20-bit input.
  localparam int                    MS_PER_S_W    = 10;
  localparam logic [MS_PER_S_W-1:0] MS_PER_S      = 10'd1000;
  localparam int                    USEC_RECIP_W  = 21;
  localparam logic [USEC_RECIP_W-1:0] USEC_RECIP  = 21'd1073742;
  localparam int                    RECIP_SHIFT   = 30;
  localparam int                    USEC_MS_W     = 11;

  // The slot index is the sequence number reduced one byte per cycle.
  localparam int DIGIT_W   = 8;
  localparam int MOD_STEPS = (FSEQ_W + DIGIT_W - 1) / DIGIT_W;
  localparam int SEQ_PAD_W = MOD_STEPS * DIGIT_W;
  localparam int STEP_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_WRITE,
    ST_OWN_RD,
    ST_OWN_WAIT,
    ST_SCAN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic write;
    logic own_rd;
    logic own_cap;
    logic scan;
    logic result;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic scan_done;
  } dp_status_t;

  typedef struct packed {
    logic [COUNT_W-1:0] cam_count;
    logic [TOL_W-1:0]   tol;
  } cfg_t;

  function automatic logic within_tol(input logic [TIME_W-1:0] a,
                                      input logic [TIME_W-1:0] b,
                                      input logic [TOL_W-1:0]  tol);
    logic [TIME_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return d <= TIME_W'(tol);
  endfunction

  // Folds one byte, most significant bit first, into a running remainder mod SLOTS.
  function automatic logic [SLOT_W-1:0] mod_digit(input logic [SLOT_W-1:0]  r,
                                                  input logic [DIGIT_W-1:0] digit);
    logic [SLOT_W:0]   t;
    logic [SLOT_W-1:0] acc;
    acc = r;
    for (int b = DIGIT_W - 1; b >= 0; b--) begin
      t = {acc, digit[b]};
      if (t >= (SLOT_W + 1)'(SLOTS)) begin
        t = t - (SLOT_W + 1)'(SLOTS);
      end
      acc = t[SLOT_W-1:0];
    end
    return acc;
  endfunction

endpackage

// ===== design/mcfsc_cfg.sv =====
// Configuration register file of the frame sync checker.
// Depends on mcfsc_pkg; feeds the effective camera count and tolerance to the datapath.
module mcfsc_cfg import mcfsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [COUNT_W-1:0] sync_camera_count;
  logic [TOL_W-1:0]   match_tolerance_ms;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_camera_count  <= '0;
      match_tolerance_ms <= TOL_W'(2);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SYNC_COUNT: sync_camera_count  <= cfg_data[COUNT_W-1:0];
        CFG_TOLERANCE:  match_tolerance_ms <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // The count saturates at the number of cameras that exist.
  always_comb begin
    cfg.cam_count = (int'(sync_camera_count) > CAMERAS) ? COUNT_W'(CAMERAS)
                                                        : sync_camera_count;
    cfg.tol       = match_tolerance_ms;
  end

endmodule

// ===== design/mcfsc_ctrl.sv =====
// Sequencing state machine of the frame sync checker.
// Depends on mcfsc_pkg; drives the datapath through dp_cmd_t and reads dp_status_t.
module mcfsc_ctrl import mcfsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       done
);

  state_t            state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_MOD;
          cnt_next   = '0;
        end
      end
      ST_MOD: begin
        if (cnt == STEP_W'(MOD_STEPS - 1)) begin
          state_next = (status.is_query == KIND_QUERY) ? ST_OWN_RD : ST_WRITE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_WRITE:    state_next = ST_IDLE;
      ST_OWN_RD:   state_next = ST_OWN_WAIT;
      ST_OWN_WAIT: state_next = ST_SCAN;
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT:   state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_MOD:      cmd.mod_step = 1'b1;
      ST_WRITE:    cmd.write    = 1'b1;
      ST_OWN_RD:   cmd.own_rd   = 1'b1;
      ST_OWN_WAIT: cmd.own_cap  = 1'b1;
      ST_SCAN:     cmd.scan     = 1'b1;
      ST_RESULT:   cmd.result   = 1'b1;
      default:     busy         = 1'b0;
    endcase
    done = cmd.result;
  end

endmodule

// ===== design/mcfsc_dp.sv =====
// Datapath of the frame sync checker: slot memory, time conversion, scan and ring check.
// Depends on mcfsc_pkg; steered by mcfsc_ctrl, configured by mcfsc_cfg.
module mcfsc_dp import mcfsc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [KIND_W-1:0]   kind,
  input  logic [CAM_ID_W-1:0] camera_id,
  input  logic [FSEQ_W-1:0]   frame_sequence,
  input  logic [SEC_W-1:0]    sof_seconds,
  input  logic [USEC_W-1:0]   sof_microseconds,
  input  cfg_t                cfg,
  input  dp_cmd_t             cmd,
  output dp_status_t          status,
  output logic                frames_synced
);

  logic [KIND_W-1:0]    kind_q;
  logic [CAM_ID_W-1:0]  cam_q;
  logic [SEQ_PAD_W-1:0] seq_sh;
  logic [SLOT_W-1:0]    slot_q;
  logic [SEC_W-1:0]     sec_q;
  logic [USEC_W-1:0]    usec_q;
  logic [TIME_W-1:0]    sec_ms_q;
  logic [USEC_MS_W-1:0] usec_ms_q;

  logic [TIME_W-1:0] mem [CAMERAS][SLOTS];
  logic              valid [CAMERAS][SLOTS];
  logic [TIME_W-1:0] rdata;
  logic              rd_ok;
  logic [TIME_W-1:0] cur;

  logic [CI_W-1:0]   ci;
  logic [SJ_W-1:0]   sj;
  logic              pend;
  logic [HIT_W-1:0]  hits;
  logic              fail;
  logic [TIME_W-1:0] first;
  logic [TIME_W-1:0] last;

  logic [SEC_W+MS_PER_S_W-1:0]    sec_prod;
  logic [USEC_W+USEC_RECIP_W-1:0] usec_prod;
  logic [TIME_W-1:0]              time_new;
  logic                           cam_oob;
  logic [CAM_W-1:0]               cam_idx;
  logic [CAM_W-1:0]               ci_idx;
  logic [SLOT_W-1:0]              sj_idx;
  logic                           at_end_cam;
  logic                           slot_end;
  logic                           skip_cam;
  logic                           hit;
  logic                           pair_bad;
  logic                           ring_bad;
  logic                           scan_issue;
  logic                           wr_en;
  logic                           rd_en;
  logic [CAM_W-1:0]               rd_cam;
  logic [SLOT_W-1:0]              rd_slot;

  always_comb begin
    sec_prod  = sec_q * MS_PER_S;
    usec_prod = usec_q * USEC_RECIP;
    time_new  = sec_ms_q + TIME_W'(usec_ms_q);
    cam_oob   = (int'(cam_q) >= CAMERAS);
    cam_idx   = CAM_W'(cam_q);
    ci_idx    = ci[CAM_W-1:0];
    sj_idx    = sj[SLOT_W-1:0];

    at_end_cam = (ci == CI_W'(CAMERAS));
    slot_end   = (sj == SJ_W'(SLOTS));
    // A camera takes part only if its slot 0 is valid, and the queried camera never does.
    skip_cam   = (sj == '0) && ((int'(ci) == int'(cam_q)) || !valid[ci_idx][0]);
    hit        = pend && rd_ok && within_tol(rdata, cur, cfg.tol);

    // Consecutive recorded entries are compared while the list is built; the entry at
    // position count minus two closes the ring against the first one as well.
    pair_bad = (int'(hits) >= 1) && (int'(hits) <= int'(cfg.cam_count) - 2) &&
               !within_tol(last, rdata, cfg.tol);
    ring_bad = (int'(hits) >= 1) && (int'(hits) == int'(cfg.cam_count) - 2) &&
               !within_tol(rdata, first, cfg.tol);

    scan_issue = cmd.scan && !hit && !at_end_cam && !skip_cam && !slot_end;
    wr_en      = cmd.write && !cam_oob;
    rd_en      = cmd.own_rd || scan_issue;
    rd_cam     = cmd.own_rd ? cam_idx : ci_idx;
    rd_slot    = cmd.own_rd ? slot_q : sj_idx;

    status.is_query  = kind_q[0];
    status.scan_done = at_end_cam;

    if (int'(cfg.cam_count) < 2) begin
      frames_synced = 1'b1;
    end else begin
      frames_synced = (int'(hits) >= int'(cfg.cam_count) - 1) && !fail;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      cam_q  <= camera_id;
      seq_sh <= SEQ_PAD_W'(frame_sequence);
      sec_q  <= sof_seconds;
      usec_q <= sof_microseconds;
      slot_q <= '0;
    end else if (cmd.mod_step) begin
      slot_q    <= mod_digit(slot_q, seq_sh[SEQ_PAD_W-1 -: DIGIT_W]);
      seq_sh    <= seq_sh << DIGIT_W;
      sec_ms_q  <= TIME_W'(sec_prod);
      usec_ms_q <= usec_prod[RECIP_SHIFT +: USEC_MS_W];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cam_idx][slot_q] <= time_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_cam][rd_slot];
      rd_ok <= valid[rd_cam][rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.own_cap) begin
      cur <= (cam_oob || !rd_ok) ? '0 : rdata;
    end
    if (cmd.scan && hit) begin
      if (hits == '0) begin
        first <= rdata;
      end
      last <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CAMERAS; c++) begin
        for (int s = 0; s < SLOTS; s++) begin
          valid[c][s] <= 1'b0;
        end
      end
      ci   <= '0;
      sj   <= '0;
      pend <= 1'b0;
      hits <= '0;
      fail <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[cam_idx][slot_q] <= 1'b1;
      end
      if (cmd.own_cap) begin
        ci   <= '0;
        sj   <= '0;
        pend <= 1'b0;
        hits <= '0;
        fail <= 1'b0;
      end else if (cmd.scan) begin
        // A hit moves on to the next camera; no read is issued in that cycle.
        priority if (hit) begin
          hits <= hits + 1'b1;
          fail <= fail | pair_bad | ring_bad;
          ci   <= ci + 1'b1;
          sj   <= '0;
          pend <= 1'b0;
        end else if (!at_end_cam) begin
          if (skip_cam || slot_end) begin
            ci   <= ci + 1'b1;
            sj   <= '0;
            pend <= 1'b0;
          end else begin
            sj   <= sj + 1'b1;
            pend <= 1'b1;
          end
        end else begin
          // Every camera has been looked at; the scan registers hold their values for the result.
        end
      end
    end
  end

endmodule

// ===== design/multi_camera_frame_sync_check_top.sv =====
// Multi-camera frame sync checker, top level. Depends on mcfsc_pkg, mcfsc_cfg,
// mcfsc_ctrl and mcfsc_dp.
//
// An item is taken when start is high and busy is low; its fields are sampled then.
// A write item (kind 0) stores the start-of-frame time of one camera slot and gives
// no result; busy stays high until its write is made. A query item (kind 1) gives one word on
// frames_synced, marked by a one-cycle done strobe that the receiver must take.
// A query keeps busy high until its result, with done in the last busy cycle; the
// length is set by the scan of the other cameras' slots through the single read port,
// one slot per cycle. Both kinds first reduce the sequence number to a slot index.
// Configuration words go in on cfg_valid/cfg_index/cfg_data; cfg_ready is always
// high. The user must make writes only while busy is low; the block does not enforce it.
// Reset clears every slot's valid bit at once, sets the camera count to 0 and the
// tolerance to 2 ms; there is no clearing pass, so the block is ready right away.
// The receiver cannot stall, so done never waits.
module multi_camera_frame_sync_check_top import mcfsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [KIND_W-1:0]     kind,
  input  logic [CAM_ID_W-1:0]   camera_id,
  input  logic [FSEQ_W-1:0]     frame_sequence,
  input  logic [SEC_W-1:0]      sof_seconds,
  input  logic [USEC_W-1:0]     sof_microseconds,
  output logic                  done,
  output logic                  frames_synced,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  mcfsc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mcfsc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  mcfsc_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .kind             (kind),
    .camera_id        (camera_id),
    .frame_sequence   (frame_sequence),
    .sof_seconds      (sof_seconds),
    .sof_microseconds (sof_microseconds),
    .cfg              (cfg),
    .cmd              (cmd),
    .status           (status),
    .frames_synced    (frames_synced)
  );

endmodule

// ===== design/mcfsc_checker.sv =====
// Port-level checker for the frame sync checker, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module mcfsc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // An accepted item keeps the block busy until its work is finished.
  `MCFSC_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // No result appears in the cycle right after an item is taken.
  `MCFSC_ASSERT_NEXT(a_accept_no_done, clk, rst, start && !busy, !done)
  // A result is only shown while the block still counts as busy.
  `MCFSC_ASSERT_IMP(a_done_busy, clk, rst, done, busy)
  // After the result the block is idle and the strobe is gone.
  `MCFSC_ASSERT_NEXT(a_done_idle, clk, rst, done, !busy && !done)

endmodule

bind multi_camera_frame_sync_check_top mcfsc_checker u_mcfsc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
